[hdl/lottery_ticket_scheduler_macros.svh]
// ----------------------------------------------------------------------------
// Lottery ticket scheduler assertion macros
// Shared property forms for the checker bound to the scheduler top level.
// ----------------------------------------------------------------------------
`ifndef LOTTERY_TICKET_SCHEDULER_MACROS_SVH
`define LOTTERY_TICKET_SCHEDULER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lottery ticket scheduler check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lottery ticket scheduler check failed");

`endif

[hdl/lts_pkg.sv]
// ----------------------------------------------------------------------------
// Lottery ticket scheduler package
// Sizes, codes and the command and status bundles shared by all modules.
// ----------------------------------------------------------------------------
package lts_pkg;

    // Sizing of the ticket table.
    localparam int MAX_PROCS  = 16;
    localparam int MAX_REFILL = 15;

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int N_W   = $clog2(MAX_PROCS + 1);
    localparam int CNT_W = $clog2(MAX_REFILL + 1);
    localparam int TOT_W = $clog2(MAX_PROCS * MAX_REFILL + 1);

    // Fixed field widths of the ports.
    localparam int OP_W       = 2;
    localparam int RND_W      = 31;
    localparam int PID_W      = 4;
    localparam int WIN_W      = 4;
    localparam int POS_W      = 8;
    localparam int TOT_OUT_W  = 8;
    localparam int REFILL_W   = 4;
    localparam int ACTIVE_W   = 5;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int MOD_CNT_W  = $clog2(RND_W);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TICKET_REFILL    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PROCESSES = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [REFILL_W-1:0] REFILL_RESET = 4'd5;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd15;

    // Operation codes of an input item.
    typedef enum logic [OP_W-1:0] {
        OP_INIT   = 2'd0,
        OP_DRAW   = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic do_init;
        logic do_finish;
        logic sum_step;
        logic mod_start;
        logic mod_step;
        logic walk_step;
        logic do_update;
        logic load_result;
        logic result_win;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sum_done;
        logic total_zero;
        logic mod_last;
        logic walk_hit;
    } status_t;

endpackage

[hdl/lts_ctrl.sv]
// ----------------------------------------------------------------------------
// Lottery ticket scheduler controller
// Sequences one item at a time: init, finish, or draw sum, modulo, walk, update.
// ----------------------------------------------------------------------------
module lts_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lts_pkg::OP_W-1:0]    opcode,
    output logic                        out_valid,
    input  logic                        out_stall,
    output lts_pkg::cmd_t               cmd,
    input  lts_pkg::status_t            status
);
    import lts_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_INIT   = 9'b000000010,
        S_FINISH = 9'b000000100,
        S_SUM    = 9'b000001000,
        S_CHECK  = 9'b000010000,
        S_MOD    = 9'b000100000,
        S_WALK   = 9'b001000000,
        S_UPDATE = 9'b010000000,
        S_RESULT = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   win_reg;
    logic   win_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The output register is free when empty or being taken this cycle.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // Next-state and command decode.
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        win_next       = win_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    win_next   = 1'b0;
                    case (opcode_t'(opcode))
                        OP_INIT:   state_next = S_INIT;
                        OP_DRAW:   state_next = S_SUM;
                        OP_FINISH: state_next = S_FINISH;
                        default:   state_next = S_RESULT;
                    endcase
                end
            end
            S_INIT:
            begin
                cmd.do_init = 1'b1;
                state_next  = S_RESULT;
            end
            S_FINISH:
            begin
                cmd.do_finish = 1'b1;
                state_next    = S_RESULT;
            end
            S_SUM:
            begin
                if (status.sum_done)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.sum_step = 1'b1;
                end
            end
            S_CHECK:
            begin
                if (status.total_zero)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.mod_start = 1'b1;
                    state_next    = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (status.mod_last)
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_hit)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.do_update = 1'b1;
                win_next      = 1'b1;
                state_next    = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    cmd.load_result = 1'b1;
                    cmd.result_win  = win_reg;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            win_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            win_reg       <= win_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hdl/lts_dpath.sv]
// ----------------------------------------------------------------------------
// Lottery ticket scheduler datapath
// Ticket table, configuration, running sum, serial modulo and result register.
// ----------------------------------------------------------------------------
module lts_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [lts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lts_pkg::CFG_W-1:0]         cfg_data,
    input  logic [lts_pkg::RND_W-1:0]         random_word,
    input  logic [lts_pkg::PID_W-1:0]         process_id,
    input  lts_pkg::cmd_t                     cmd,
    output lts_pkg::status_t                  status,
    output logic                              winner_valid,
    output logic [lts_pkg::WIN_W-1:0]         winner_id,
    output logic [lts_pkg::POS_W-1:0]         drawn_position,
    output logic [lts_pkg::TOT_OUT_W-1:0]     total_tickets
);
    import lts_pkg::*;

    logic [REFILL_W-1:0]  refill_cfg_reg;
    logic [ACTIVE_W-1:0]  active_cfg_reg;
    logic [CNT_W-1:0]     counts_reg [MAX_PROCS];

    logic [RND_W-1:0]     rnd_reg;
    logic [PID_W-1:0]     pid_reg;
    logic [N_W-1:0]       idx_reg;
    logic [TOT_W-1:0]     total_reg;
    logic [TOT_W-1:0]     acc_reg;
    logic [TOT_W-1:0]     rem_reg;
    logic [TOT_W-1:0]     rem_next;
    logic [MOD_CNT_W-1:0] mod_cnt_reg;
    logic [IDX_W-1:0]     winner_reg;
    logic [CNT_W-1:0]     win_cnt_reg;

    logic                 winner_valid_reg;
    logic [WIN_W-1:0]     winner_id_reg;
    logic [POS_W-1:0]     drawn_position_reg;
    logic [TOT_OUT_W-1:0] total_tickets_reg;

    logic [N_W-1:0]       n_eff;
    logic [CNT_W-1:0]     refill_eff;
    logic [CNT_W-1:0]     rd_cnt;
    logic [TOT_W-1:0]     acc_sum;
    logic [TOT_W:0]       trial;
    logic [TOT_W:0]       tot_ext;

    // Clamp the configuration to the table size and count range.
    assign n_eff      = (int'(active_cfg_reg) > MAX_PROCS) ? N_W'(MAX_PROCS)
                                                           : N_W'(active_cfg_reg);
    assign refill_eff = (int'(refill_cfg_reg) > MAX_REFILL) ? CNT_W'(MAX_REFILL)
                                                            : CNT_W'(refill_cfg_reg);

    // Single read port of the ticket table, addressed by the scan index.
    assign rd_cnt  = counts_reg[idx_reg[IDX_W-1:0]];
    assign acc_sum = acc_reg + TOT_W'(rd_cnt);

    // One restoring division step: shift in the next random bit.
    assign trial   = {rem_reg, rnd_reg[RND_W-1]};
    assign tot_ext = {1'b0, total_reg};
    assign rem_next = (trial >= tot_ext) ? TOT_W'(trial - tot_ext) : TOT_W'(trial);

    // Status back to the controller.
    assign status.sum_done   = !(idx_reg < n_eff);
    assign status.total_zero = (total_reg == '0);
    assign status.mod_last   = (mod_cnt_reg == MOD_CNT_W'(RND_W - 1));
    assign status.walk_hit   = (rem_reg < acc_sum) || (idx_reg == n_eff - N_W'(1));

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refill_cfg_reg <= REFILL_RESET;
            active_cfg_reg <= ACTIVE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TICKET_REFILL:    refill_cfg_reg <= cfg_data[REFILL_W-1:0];
                CFG_ACTIVE_PROCESSES: active_cfg_reg <= cfg_data[ACTIVE_W-1:0];
                default:              ;
            endcase
        end
    end

    // Ticket table: init, finish and the post-draw decrement with reload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PROCS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < MAX_PROCS; i++)
            begin
                if (cmd.do_init)
                begin
                    counts_reg[i] <= (N_W'(i) < n_eff) ? refill_eff : '0;
                end
                else if (cmd.do_finish && (int'(pid_reg) == i))
                begin
                    counts_reg[i] <= '0;
                end
                else if (cmd.do_update && (winner_reg == IDX_W'(i)))
                begin
                    counts_reg[i] <= (win_cnt_reg == CNT_W'(1)) ? refill_eff
                                                                : win_cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    // Working registers of a draw.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rnd_reg   <= random_word;
            pid_reg   <= process_id;
            idx_reg   <= '0;
            total_reg <= '0;
        end
        if (cmd.sum_step)
        begin
            total_reg <= total_reg + TOT_W'(rd_cnt);
            idx_reg   <= idx_reg + N_W'(1);
        end
        if (cmd.mod_start)
        begin
            rem_reg     <= '0;
            mod_cnt_reg <= '0;
            idx_reg     <= '0;
            acc_reg     <= '0;
        end
        if (cmd.mod_step)
        begin
            rem_reg     <= rem_next;
            rnd_reg     <= {rnd_reg[RND_W-2:0], 1'b0};
            mod_cnt_reg <= mod_cnt_reg + MOD_CNT_W'(1);
        end
        if (cmd.walk_step)
        begin
            if (status.walk_hit)
            begin
                winner_reg  <= idx_reg[IDX_W-1:0];
                win_cnt_reg <= rd_cnt;
            end
            else
            begin
                idx_reg <= idx_reg + N_W'(1);
                acc_reg <= acc_sum;
            end
        end
    end

    // Result register: zero fields unless a draw found a winner.
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            if (cmd.result_win)
            begin
                winner_valid_reg   <= 1'b1;
                winner_id_reg      <= WIN_W'(winner_reg);
                drawn_position_reg <= POS_W'(rem_reg);
                total_tickets_reg  <= TOT_OUT_W'(total_reg);
            end
            else
            begin
                winner_valid_reg   <= 1'b0;
                winner_id_reg      <= '0;
                drawn_position_reg <= '0;
                total_tickets_reg  <= '0;
            end
        end
    end

    assign winner_valid   = winner_valid_reg;
    assign winner_id      = winner_id_reg;
    assign drawn_position = drawn_position_reg;
    assign total_tickets  = total_tickets_reg;

endmodule

[hdl/lottery_ticket_scheduler.sv]
// ----------------------------------------------------------------------------
// Lottery ticket scheduler
// Ticket-count lottery: init, draw a weighted winner, and finish a process.
// ----------------------------------------------------------------------------
// One item is handled at a time and every item returns one result item. Init
// and finish pass through their own state and then the result state, and the
// unused opcode goes straight to the result state, which waits while the
// output register is full and held. A draw sums the active processes' counts
// through the table's single read port, runs a one-bit-per-cycle restoring
// modulo of the random word, walks the cumulative counts, and passes through
// check, update and result states. A draw on an empty lottery ends after the
// sum. A new item is accepted as soon as the previous result sits in the output
// register, even while it waits to be taken.
module lottery_ticket_scheduler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [lts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lts_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lts_pkg::OP_W-1:0]          opcode,
    input  logic [lts_pkg::RND_W-1:0]         random_word,
    input  logic [lts_pkg::PID_W-1:0]         process_id,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              winner_valid,
    output logic [lts_pkg::WIN_W-1:0]         winner_id,
    output logic [lts_pkg::POS_W-1:0]         drawn_position,
    output logic [lts_pkg::TOT_OUT_W-1:0]     total_tickets
);
    import lts_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer.
    lts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // Ticket table and arithmetic.
    lts_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .random_word    (random_word),
        .process_id     (process_id),
        .cmd            (cmd),
        .status         (status),
        .winner_valid   (winner_valid),
        .winner_id      (winner_id),
        .drawn_position (drawn_position),
        .total_tickets  (total_tickets)
    );

endmodule

[hdl/lts_checker.sv]
// ----------------------------------------------------------------------------
// Lottery ticket scheduler checker
// Port-level assertions, bound to the scheduler top level.
// ----------------------------------------------------------------------------
`include "lottery_ticket_scheduler_macros.svh"

module lts_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic                              winner_valid,
    input  logic [lts_pkg::WIN_W-1:0]         winner_id,
    input  logic [lts_pkg::POS_W-1:0]         drawn_position,
    input  logic [lts_pkg::TOT_OUT_W-1:0]     total_tickets
);
    import lts_pkg::*;

    logic in_take;
    logic out_held;
    logic out_win;
    logic out_no_win;
    logic fields_zero;

    // Handshake and field summaries used by the checks below.
    assign in_take     = in_valid && !in_stall;
    assign out_held    = out_valid && out_stall;
    assign out_win     = out_valid && winner_valid;
    assign out_no_win  = out_valid && !winner_valid;
    assign fields_zero = (winner_id == '0) && (drawn_position == '0)
                         && (total_tickets == '0);

    // A result that is held back stays offered.
    `LTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid)

    // Once an item is taken the block is busy with it.
    `LTS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_take, in_stall)

    // A winner's position lies inside the ticket total.
    `LTS_ASSERT_SAME(a_pos_in_total, clk, rst_n, out_win, drawn_position < total_tickets)

    // A result without a winner carries all-zero fields.
    `LTS_ASSERT_SAME(a_no_win_zero, clk, rst_n, out_no_win, fields_zero)

endmodule

bind lottery_ticket_scheduler lts_checker u_lts_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .winner_valid   (winner_valid),
    .winner_id      (winner_id),
    .drawn_position (drawn_position),
    .total_tickets  (total_tickets)
);

[dv/lottery_ticket_scheduler_test.sv]
// ----------------------------------------------------------------------------
// Lottery ticket scheduler testbench
// Drives init, draw, finish and unused-opcode items into the scheduler under
// changing ticket settings. A directed table covers the corner cases first,
// then random phases of mostly draws follow. Every result item is checked field
// by field against the directed table or an in-bench ticket table model.
// ----------------------------------------------------------------------------
module lottery_ticket_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lts_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 2 * MAX_PROCS + 40;
    localparam int ITEM_TARGET  = 700;

    // One result item of the scheduler.
    typedef struct packed {
        logic                 winner_valid;
        logic [WIN_W-1:0]     winner_id;
        logic [POS_W-1:0]     drawn_position;
        logic [TOT_OUT_W-1:0] total_tickets;
    } sched_result_t;

    // One row of the directed table: an item or a register write.
    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        opcode_t              op;
        logic [RND_W-1:0]     rnd;
        logic [PID_W-1:0]     pid;
        bit                   typed;
        sched_result_t        res;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     val;
    } plan_row_t;

    // Ports of the block.
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [OP_W-1:0]      opcode = '0;
    logic [RND_W-1:0]     random_word = '0;
    logic [PID_W-1:0]     process_id = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 winner_valid;
    logic [WIN_W-1:0]     winner_id;
    logic [POS_W-1:0]     drawn_position;
    logic [TOT_OUT_W-1:0] total_tickets;

    // Model of the ticket table and its settings.
    logic [CNT_W-1:0]    tickets [MAX_PROCS];
    logic [REFILL_W-1:0] refill_cfg;
    logic [ACTIVE_W-1:0] active_cfg;

    sched_result_t outcome_fifo [$];
    sched_result_t head_outcome;
    plan_row_t     plan [$];

    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned stall_mode = 0;

    lottery_ticket_scheduler DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .random_word    (random_word),
        .process_id     (process_id),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .winner_valid   (winner_valid),
        .winner_id      (winner_id),
        .drawn_position (drawn_position),
        .total_tickets  (total_tickets)
    );

    always #5 clk = ~clk;

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("lottery_ticket_scheduler_test NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Applies one item to the ticket table model and returns its result.
    function automatic sched_result_t lottery_step(input opcode_t op,
                                                   input logic [RND_W-1:0] rnd,
                                                   input logic [PID_W-1:0] pid);
        sched_result_t res;
        int unsigned   n;
        int unsigned   refill;
        int unsigned   total;
        int unsigned   pos;
        int unsigned   acc;
        int unsigned   win;
        bit            found;
        int            i;

        res = '0;
        n = (active_cfg > MAX_PROCS) ? MAX_PROCS : active_cfg;
        refill = (refill_cfg > MAX_REFILL) ? MAX_REFILL : refill_cfg;
        case (op)
            OP_INIT:
            begin
                for (i = 0; i < MAX_PROCS; i++)
                    tickets[i] = (i < n) ? CNT_W'(refill) : '0;
            end
            OP_DRAW:
            begin
                total = 0;
                for (i = 0; i < n; i++)
                    total += tickets[i];
                if (total != 0)
                begin
                    pos = rnd % total;
                    acc = 0;
                    win = n - 1;
                    found = 1'b0;
                    for (i = 0; i < n; i++)
                    begin
                        acc += tickets[i];
                        if (!found && pos < acc)
                        begin
                            win = i;
                            found = 1'b1;
                        end
                    end
                    tickets[win] = tickets[win] - 1'b1;
                    if (tickets[win] == 0)
                        tickets[win] = CNT_W'(refill);
                    res.winner_valid   = 1'b1;
                    res.winner_id      = WIN_W'(win);
                    res.drawn_position = POS_W'(pos);
                    res.total_tickets  = TOT_OUT_W'(total);
                end
            end
            OP_FINISH:
            begin
                if (pid < MAX_PROCS)
                    tickets[pid] = '0;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Random word with the extremes and small values weighted up.
    function automatic logic [RND_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return RND_W'($urandom_range(0, 255));
            default: return RND_W'($urandom());
        endcase
    endfunction

    function automatic void add_item(input opcode_t op, input logic [RND_W-1:0] rnd,
                                     input logic [PID_W-1:0] pid);
        plan_row_t row;
        row = '{ROW_ITEM, op, rnd, pid, 1'b0, '0, '0, '0};
        plan.push_back(row);
    endfunction

    function automatic void add_check(input opcode_t op, input logic [RND_W-1:0] rnd,
                                      input logic [PID_W-1:0] pid, input logic v,
                                      input logic [WIN_W-1:0] w, input logic [POS_W-1:0] p,
                                      input logic [TOT_OUT_W-1:0] t);
        plan_row_t row;
        row = '{ROW_ITEM, op, rnd, pid, 1'b1, {v, w, p, t}, '0, '0};
        plan.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] val);
        plan_row_t row;
        row = '{ROW_CFG, OP_NONE, '0, '0, 1'b0, '0, idx, val};
        plan.push_back(row);
    endfunction

    // Offers one item and waits until it is taken; the outcome is queued then.
    task automatic send_item(input opcode_t op, input logic [RND_W-1:0] rnd,
                             input logic [PID_W-1:0] pid, input bit typed,
                             input sched_result_t typed_res);
        sched_result_t pred;
        in_valid    <= 1'b1;
        opcode      <= op;
        random_word <= rnd;
        process_id  <= pid;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        pred = lottery_step(op, rnd, pid);
        outcome_fifo.push_back(typed ? typed_res : pred);
    endtask

    task automatic idle_for(input int unsigned cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stops offering items and waits until every result item has been taken.
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (outcome_fifo.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == CFG_TICKET_REFILL)
            refill_cfg = val[REFILL_W-1:0];
        else
            active_cfg = val[ACTIVE_W-1:0];
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver stall pattern, chosen per phase.
    function automatic logic pick_stall();
        case (stall_mode)
            0: return 1'b0;
            1: return ($urandom_range(0, 3) == 0);
            2: return ($urandom_range(0, 3) != 0);
            default: return ((cycle_count % 37) < 20);
        endcase
    endfunction

    // Result checking against the oldest queued outcome.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (outcome_fifo.size() == 0)
                report_mismatch("result item with nothing outstanding");
            else
            begin
                head_outcome = outcome_fifo.pop_front();
                if (winner_valid !== head_outcome.winner_valid)
                    report_mismatch($sformatf("winner_valid got %0d, want %0d",
                                              winner_valid, head_outcome.winner_valid));
                if (winner_id !== head_outcome.winner_id)
                    report_mismatch($sformatf("winner_id got %0d, want %0d",
                                              winner_id, head_outcome.winner_id));
                if (drawn_position !== head_outcome.drawn_position)
                    report_mismatch($sformatf("drawn_position got %0d, want %0d",
                                              drawn_position, head_outcome.drawn_position));
                if (total_tickets !== head_outcome.total_tickets)
                    report_mismatch($sformatf("total_tickets got %0d, want %0d",
                                              total_tickets, head_outcome.total_tickets));
            end
        end
        out_stall <= pick_stall();
    end

    // Stimulus.
    initial
    begin
        plan_row_t        row;
        opcode_t          op;
        logic [CFG_W-1:0] refill_val;
        logic [CFG_W-1:0] active_val;
        int unsigned      sent;
        int unsigned      burst_left;
        int unsigned      phase_len;
        int unsigned      k;
        bit               gaps_on;

        refill_cfg = REFILL_RESET;
        active_cfg = ACTIVE_RESET;
        for (k = 0; k < MAX_PROCS; k++)
            tickets[k] = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: empty lottery, no-op items, then the first draws.
        add_check(OP_DRAW, '1, 4'd0, 1'b0, 4'd0, 8'd0, 8'd0);
        add_check(OP_FINISH, '0, 4'd15, 1'b0, 4'd0, 8'd0, 8'd0);
        add_check(OP_NONE, '1, 4'd15, 1'b0, 4'd0, 8'd0, 8'd0);
        add_check(OP_INIT, '0, 4'd0, 1'b0, 4'd0, 8'd0, 8'd0);
        add_check(OP_DRAW, '0, 4'd0, 1'b1, 4'd0, 8'd0, 8'd75);
        add_item(OP_DRAW, '1, 4'd0);
        add_check(OP_FINISH, rand_word(), 4'd0, 1'b0, 4'd0, 8'd0, 8'd0);
        add_item(OP_DRAW, rand_word(), PID_W'($urandom_range(0, 15)));
        // Finish of an inactive slot, and the unused opcode with random fields.
        add_check(OP_FINISH, '0, 4'd15, 1'b0, 4'd0, 8'd0, 8'd0);
        add_check(OP_NONE, rand_word(), PID_W'($urandom_range(0, 15)),
                  1'b0, 4'd0, 8'd0, 8'd0);

        // Single process with a single ticket: every draw hits it and reloads.
        add_cfg(CFG_TICKET_REFILL, 5'd1);
        add_cfg(CFG_ACTIVE_PROCESSES, 5'd1);
        add_check(OP_INIT, '0, 4'd0, 1'b0, 4'd0, 8'd0, 8'd0);
        add_check(OP_DRAW, '1, 4'd0, 1'b1, 4'd0, 8'd0, 8'd1);
        add_check(OP_DRAW, 31'd12345, 4'd0, 1'b1, 4'd0, 8'd0, 8'd1);

        // Full table: active count above the table size, largest refill.
        add_cfg(CFG_ACTIVE_PROCESSES, 5'd31);
        add_cfg(CFG_TICKET_REFILL, 5'd15);
        add_check(OP_INIT, '0, 4'd0, 1'b0, 4'd0, 8'd0, 8'd0);
        add_check(OP_DRAW, 31'd239, 4'd0, 1'b1, 4'd15, 8'd239, 8'd240);
        // Slots beyond the active count drop out of the draw but keep counts.
        add_cfg(CFG_ACTIVE_PROCESSES, 5'd4);
        add_check(OP_DRAW, 31'd59, 4'd0, 1'b1, 4'd3, 8'd59, 8'd60);
        add_cfg(CFG_ACTIVE_PROCESSES, 5'd16);
        add_item(OP_DRAW, '1, 4'd0);

        // Zero refill: an emptied count stays empty until the lottery is empty.
        add_cfg(CFG_TICKET_REFILL, 5'd1);
        add_cfg(CFG_ACTIVE_PROCESSES, 5'd2);
        add_check(OP_INIT, '0, 4'd0, 1'b0, 4'd0, 8'd0, 8'd0);
        add_cfg(CFG_TICKET_REFILL, 5'd0);
        add_check(OP_DRAW, '0, 4'd0, 1'b1, 4'd0, 8'd0, 8'd2);
        add_check(OP_DRAW, '0, 4'd0, 1'b1, 4'd1, 8'd0, 8'd1);
        add_check(OP_DRAW, '1, 4'd0, 1'b0, 4'd0, 8'd0, 8'd0);

        // No active process: init clears the whole table.
        add_cfg(CFG_ACTIVE_PROCESSES, 5'd0);
        add_cfg(CFG_TICKET_REFILL, 5'h13);
        add_check(OP_INIT, '0, 4'd0, 1'b0, 4'd0, 8'd0, 8'd0);
        add_check(OP_DRAW, '1, 4'd0, 1'b0, 4'd0, 8'd0, 8'd0);
        add_cfg(CFG_ACTIVE_PROCESSES, 5'd16);
        add_check(OP_DRAW, '1, 4'd0, 1'b0, 4'd0, 8'd0, 8'd0);

        // Walk the directed table with a mild stall pattern.
        stall_mode = 1;
        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == ROW_CFG)
            begin
                wait_drain();
                write_reg(row.idx, row.val);
            end
            else
                send_item(row.op, row.rnd, row.pid, row.typed, row.res);
        end

        // Random phases: new settings, an init, then mostly draws.
        sent = 0;
        while (sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 5))
                0: refill_val = '0;
                1: refill_val = 5'd1;
                2: refill_val = 5'd15;
                3: refill_val = CFG_W'($urandom_range(16, 31));
                default: refill_val = CFG_W'($urandom_range(1, 15));
            endcase
            case ($urandom_range(0, 6))
                0: active_val = '0;
                1: active_val = 5'd1;
                2: active_val = 5'd16;
                3: active_val = CFG_W'($urandom_range(17, 31));
                default: active_val = CFG_W'($urandom_range(2, 15));
            endcase
            wait_drain();
            write_reg(CFG_TICKET_REFILL, refill_val);
            write_reg(CFG_ACTIVE_PROCESSES, active_val);

            stall_mode = $urandom_range(0, 3);
            gaps_on = ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(1, 16);
            phase_len = $urandom_range(15, 40);
            for (k = 0; k < phase_len; k++)
            begin
                if (k == 0)
                    op = OP_INIT;
                else
                begin
                    case ($urandom_range(0, 99)) inside
                        [0:71]:  op = OP_DRAW;
                        [72:83]: op = OP_FINISH;
                        [84:89]: op = OP_NONE;
                        default: op = OP_INIT;
                    endcase
                end
                send_item(op, rand_word(), PID_W'($urandom_range(0, 15)), 1'b0, '0);
                sent++;
                if (gaps_on)
                begin
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        idle_for($urandom_range(1, 15));
                        burst_left = $urandom_range(1, 16);
                    end
                end
            end
        end

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("lottery_ticket_scheduler_test OK");
        else
            $display("lottery_ticket_scheduler_test NOT OK");
        $finish;
    end

endmodule
